@@ design/assert_macros.svh @@
// Assertion macros shared by the top level and the orbit engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while the given active-low reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Check a property on the standard clock and reset.
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

@@ design/lfp_pkg.sv @@
// Shared types, constants and the log table for the Lyapunov pixel block.
`timescale 1ns / 1ps
`default_nettype none
package lfp_pkg;

  localparam int NUM_W = 39;  // col * 1.5 * 2^29 fits in 39 bits
  localparam int TERM_W = 23;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 10;

  localparam logic [31:0] RATE_LO = 32'd1342177280;  // 2.5 in Q3.29
  localparam logic [31:0] RATE_HI = 32'h8000_0000;   // 4.0 in Q3.29
  localparam logic [31:0] X_START = 32'h8000_0000;   // 0.5 in Q0.32
  localparam logic [63:0] DERIV_MIN = 64'd2306;      // 1e-15 in 2^-61 units
  localparam logic [16:0] LN2_Q16 = 17'd45426;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PATTERN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd3;

  // Control that travels with each division down the cell chain.
  typedef struct packed {
    logic valid;
    logic is_b;
  } div_ctl_t;

  // Finished result of the orbit engine.
  typedef struct packed {
    logic       done;
    logic       escaped;
    logic [3:0] level;
  } orb_res_t;

  // round(65536 * ln(1 + (k + 0.5) / 16))
  function automatic logic [15:0] ln_frac(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:  v = 16'd2017;
      4'd1:  v = 16'd5873;
      4'd2:  v = 16'd9515;
      4'd3:  v = 16'd12965;
      4'd4:  v = 16'd16242;
      4'd5:  v = 16'd19364;
      4'd6:  v = 16'd22343;
      4'd7:  v = 16'd25193;
      4'd8:  v = 16'd27924;
      4'd9:  v = 16'd30546;
      4'd10: v = 16'd33067;
      4'd11: v = 16'd35494;
      4'd12: v = 16'd37835;
      4'd13: v = 16'd40095;
      4'd14: v = 16'd42280;
      4'd15: v = 16'd44394;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/lyapunov_fractal_pixel.sv @@
// Top level: configuration, rate mapping divider chain, orbit engine, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Computes the Markus-Lyapunov tier of one grid cell per request. After a request is
// taken, the two rates are formed by a 39-cell division chain (one quotient bit per
// cell per cycle), then the orbit engine runs the logistic map, each step taking an
// x*(1-x) state and then a rate-product state, and stops early if the orbit escapes.
// One cell is in flight at a time; the result register lets the next request in while
// a finished result waits. The configuration port is always ready and must only be
// written while the block is idle.
module lyapunov_fractal_pixel #(
  parameter int WARMUP_STEPS    = 100,
  parameter int MEASURE_STEPS   = 200,
  parameter int MAX_PATTERN_LEN = 8,
  parameter int MAX_COLS        = 512,
  parameter int MAX_ROWS        = 128
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [15:0]                      s_axis_tdata,   // cell_row[6:0], cell_col[15:7]
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // level_code[3:0], zero fill
  output logic                             m_axis_tuser,   // escaped[0]
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [lfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [lfp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lfp_pkg::*;

  localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIV_W = $clog2(MAXD);
  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam logic [15:0] MAXC16 = 16'(MAX_COLS);
  localparam logic [15:0] MAXR16 = 16'(MAX_ROWS);
  localparam logic [7:0]  MAXL8  = 8'(MAX_PATTERN_LEN);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVB = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [7:0] seq_pattern_q;
  logic [3:0] seq_length_q;
  logic [9:0] grid_cols_q;
  logic [7:0] grid_rows_q;

  logic [NUM_W-1:0] rnum_q;
  logic [DIV_W-1:0] rspan_q;
  logic [31:0]      ra_q;
  logic [31:0]      rb_q;
  logic             start_q;

  logic             out_valid_q;
  logic [3:0]       out_level_q;
  logic             out_esc_q;

  logic             accept, ack;
  orb_res_t         orb_res;

  // Cell chain wiring.
  div_ctl_t         ctl_c  [0:NUM_W];
  logic [DIV_W-1:0] rem_c  [0:NUM_W];
  logic [NUM_W-1:0] word_c [0:NUM_W];
  logic [DIV_W-1:0] div_c  [0:NUM_W];

  // Grid size clamps and spans.
  logic [15:0] cols16, ncol, cspan16, rows16, nrow, rspan16;
  logic [7:0]  len8, nlen;
  logic [10:0] col3;
  logic [8:0]  row3;
  always_comb begin
    cols16  = {6'd0, grid_cols_q};
    ncol    = (cols16 == 16'd0) ? 16'd1 : ((cols16 > MAXC16) ? MAXC16 : cols16);
    cspan16 = (ncol > 16'd1) ? ncol - 16'd1 : 16'd1;
    rows16  = {8'd0, grid_rows_q};
    nrow    = (rows16 == 16'd0) ? 16'd1 : ((rows16 > MAXR16) ? MAXR16 : rows16);
    rspan16 = (nrow > 16'd1) ? nrow - 16'd1 : 16'd1;
    len8    = {4'd0, seq_length_q};
    nlen    = (len8 == 8'd0) ? 8'd1 : ((len8 > MAXL8) ? MAXL8 : len8);
    // 1.5 * 2^29 = 3 * 2^28
    col3    = {2'd0, s_axis_tdata[15:7]} * 11'd3;
    row3    = {2'd0, s_axis_tdata[6:0]} * 9'd3;
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Feed rate a on the request cycle and rate b in the following cycle.
  always_comb begin
    ctl_c[0].valid = accept || (state_q == ST_DIVB);
    ctl_c[0].is_b  = (state_q == ST_DIVB);
    rem_c[0]       = '0;
    word_c[0]      = (state_q == ST_DIVB) ? rnum_q : {col3, 28'd0};
    div_c[0]       = (state_q == ST_DIVB) ? rspan_q : cspan16[DIV_W-1:0];
  end

  genvar g;
  generate
    for (g = 0; g < NUM_W; g++) begin : g_cell
      lfp_div_cell #(.DIV_W(DIV_W)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_c[g]),
        .rem_i  (rem_c[g]),
        .word_i (word_c[g]),
        .div_i  (div_c[g]),
        .ctl_o  (ctl_c[g+1]),
        .rem_o  (rem_c[g+1]),
        .word_o (word_c[g+1]),
        .div_o  (div_c[g+1])
      );
    end
  endgenerate

  logic [NUM_W:0] ra_sum;
  logic [31:0]    ra_c, rb_c;
  always_comb begin
    ra_sum = {1'b0, word_c[NUM_W]} + (NUM_W + 1)'(RATE_LO);
    ra_c   = (ra_sum > (NUM_W + 1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ra_sum[31:0];
    rb_c   = (word_c[NUM_W] >= NUM_W'(RATE_HI)) ? 32'd0
           : RATE_HI - word_c[NUM_W][31:0];
  end

  lfp_orbit #(
    .WARMUP_STEPS    (WARMUP_STEPS),
    .MEASURE_STEPS   (MEASURE_STEPS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .LEN_W           (LEN_W)
  ) u_orbit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .ra_i      (ra_q),
    .rb_i      (rb_q),
    .pattern_i (seq_pattern_q),
    .len_i     (nlen[LEN_W-1:0]),
    .ack_i     (ack),
    .res_o     (orb_res)
  );

  assign ack = orb_res.done && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIVB;
      ST_DIVB: state_d = ST_WAIT;
      ST_WAIT: if (ctl_c[NUM_W].valid && ctl_c[NUM_W].is_b) state_d = ST_RUN;
      ST_RUN:  if (ack) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seq_pattern_q <= 8'd2;
      seq_length_q  <= 4'd2;
      grid_cols_q   <= 10'd80;
      grid_rows_q   <= 8'd24;
      start_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == ST_WAIT) && ctl_c[NUM_W].valid && ctl_c[NUM_W].is_b;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SEQ_PATTERN: seq_pattern_q <= cfg_data_i[7:0];
          REG_SEQ_LENGTH:  seq_length_q  <= cfg_data_i[3:0];
          REG_GRID_COLS:   grid_cols_q   <= cfg_data_i[9:0];
          REG_GRID_ROWS:   grid_rows_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (ack) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold rate-b operands, both rates from the chain and the finished result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rnum_q  <= {2'd0, row3, 28'd0};
      rspan_q <= rspan16[DIV_W-1:0];
    end
    if (ctl_c[NUM_W].valid && !ctl_c[NUM_W].is_b) begin
      ra_q <= ra_c;
    end
    if (ctl_c[NUM_W].valid && ctl_c[NUM_W].is_b) begin
      rb_q <= rb_c;
    end
    if (ack) begin
      out_level_q <= orb_res.level;
      out_esc_q   <= orb_res.escaped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_level_q};
  assign m_axis_tuser  = out_esc_q;

  `ASSERT_STD(a_busy_after_accept, accept |=> !s_axis_tready)
  `ASSERT_STD(a_done_only_running, orb_res.done |-> (state_q == ST_RUN))
  `ASSERT_STD(a_rate_b_when_waiting, (ctl_c[NUM_W].valid && ctl_c[NUM_W].is_b) |-> (state_q == ST_WAIT))

endmodule
`default_nettype wire

@@ design/lfp_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and hands on.
`timescale 1ns / 1ps
`default_nettype none
module lfp_div_cell #(
  parameter int DIV_W = 12
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  lfp_pkg::div_ctl_t        ctl_i,
  input  wire  [DIV_W-1:0]         rem_i,
  input  wire  [lfp_pkg::NUM_W-1:0] word_i,
  input  wire  [DIV_W-1:0]         div_i,
  output lfp_pkg::div_ctl_t        ctl_o,
  output logic [DIV_W-1:0]         rem_o,
  output logic [lfp_pkg::NUM_W-1:0] word_o,
  output logic [DIV_W-1:0]         div_o
);
  import lfp_pkg::*;

  logic [DIV_W:0] partial;
  logic           ge;
  logic [DIV_W:0] diff;

  // Bring down the next dividend bit; the word shifts the quotient in at the bottom.
  always_comb begin
    partial = {rem_i, word_i[NUM_W-1]};
    ge      = partial >= {1'b0, div_i};
    diff    = partial - {1'b0, div_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
    word_o <= {word_i[NUM_W-2:0], ge};
    div_o  <= div_i;
  end

endmodule
`default_nettype wire

@@ design/lfp_orbit.sv @@
// Logistic-map orbit engine with log-derivative pipeline and tier grading.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lfp_orbit #(
  parameter int WARMUP_STEPS    = 100,
  parameter int MEASURE_STEPS   = 200,
  parameter int MAX_PATTERN_LEN = 8,
  parameter int LEN_W           = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire  [31:0]       ra_i,
  input  wire  [31:0]       rb_i,
  input  wire  [7:0]        pattern_i,
  input  wire  [LEN_W-1:0]  len_i,
  input  wire               ack_i,
  output lfp_pkg::orb_res_t res_o
);
  import lfp_pkg::*;

  localparam int PW = $clog2(MAX_PATTERN_LEN);
  localparam int MAXN = (WARMUP_STEPS > MEASURE_STEPS) ? WARMUP_STEPS : MEASURE_STEPS;
  localparam int CNT_W = $clog2(MAXN + 1);
  localparam int SUM_W = TERM_W + $clog2(MEASURE_STEPS + 1);
  localparam longint U = longint'(MEASURE_STEPS) * 65536;
  localparam logic signed [63:0] TH_HI   = 64'(25 * U);
  localparam logic signed [63:0] TH_LO   = 64'(-40 * U);
  localparam logic signed [63:0] TH_S1   = 64'(-5 * U);
  localparam logic signed [63:0] TH_S2   = 64'(-15 * U);
  localparam logic signed [63:0] TH_S3   = 64'(-30 * U);
  localparam logic signed [63:0] TH_C1   = 64'(4 * U);
  localparam logic signed [63:0] TH_C2   = 64'(10 * U);
  localparam logic signed [63:0] TH_C3   = 64'(20 * U);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULP  = 3'd1;
  localparam logic [2:0] ST_MULR  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_TIER  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [31:0] ra_q, rb_q, x_q, x_d, p_q, p_d, r_q, r_d;
  logic [31:0] x_cmp;
  logic [7:0]  pat_q;
  logic [LEN_W-1:0] len_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        meas_q, meas_d, esc_q, esc_d;
  logic [3:0]  level_q, level_d;
  logic [MAX_PATTERN_LEN-1:0] pat_ext;
  logic [63:0] prod_p, prod_r;
  logic        step_esc, push;
  logic [LEN_W-1:0] pos_inc;

  // derivative / log pipeline
  logic        v0_q, v1_q, v2_q, v3_q;
  logic [31:0] x0_q, r0_q;
  logic [63:0] d1_q;
  logic [2:0]  j2_q;
  logic [11:0] w2_q;
  logic signed [TERM_W-1:0] term3_q;
  logic signed [SUM_W-1:0]  sum_q;

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN_LEN; g++) begin : g_pat
      if (g < 8) begin : g_in
        assign pat_ext[g] = pat_q[g];
      end else begin : g_zero
        assign pat_ext[g] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    // 1 - x in Q0.32; x is never zero here
    x_cmp    = (~x_q) + 32'd1;
    prod_p   = x_q * x_cmp;
    p_d      = prod_p[63:32];
    r_d      = pat_ext[pos_q] ? rb_q : ra_q;
    prod_r   = r_q * p_q;
    step_esc = (prod_r[63:29] == 35'd0) || (prod_r[63:61] != 3'd0);
    pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
    push     = (state_q == ST_MULR) && meas_q && !step_esc;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    meas_d  = meas_q;
    esc_d   = esc_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MULP;
          x_d     = X_START;
          pos_d   = '0;
          cnt_d   = '0;
          meas_d  = 1'b0;
          esc_d   = 1'b0;
        end
      end
      ST_MULP: state_d = ST_MULR;
      ST_MULR: begin
        pos_d = (pos_inc == len_q) ? '0 : pos_inc[PW-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (step_esc) begin
          esc_d   = 1'b1;
          state_d = ST_DRAIN;
        end else begin
          x_d     = prod_r[60:29];
          state_d = ST_MULP;
          if (!meas_q && cnt_q == CNT_W'(WARMUP_STEPS - 1)) begin
            // pattern phase restarts with the measured run
            meas_d = 1'b1;
            cnt_d  = '0;
            pos_d  = '0;
          end else if (meas_q && cnt_q == CNT_W'(MEASURE_STEPS - 1)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!(v0_q || v1_q || v2_q || v3_q)) begin
          state_d = ST_TIER;
        end
      end
      ST_TIER: state_d = ST_DONE;
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Grade ten times the exponent sum on step-scaled tenths; escape gives 0.
  logic signed [63:0] s_ext, s10;
  always_comb begin
    s_ext = {{(64 - SUM_W){sum_q[SUM_W-1]}}, sum_q};
    s10   = (s_ext <<< 3) + (s_ext <<< 1);
    if (esc_q || s10 >= TH_HI || s10 <= TH_LO) level_d = 4'd0;
    else if (s10 < 0) begin
      if (s10 > TH_S1)      level_d = 4'b1111;
      else if (s10 > TH_S2) level_d = 4'b1110;
      else if (s10 > TH_S3) level_d = 4'b1101;
      else                  level_d = 4'b1100;
    end else begin
      if (s10 < TH_C1)      level_d = 4'd1;
      else if (s10 < TH_C2) level_d = 4'd2;
      else if (s10 < TH_C3) level_d = 4'd3;
      else                  level_d = 4'd4;
    end
  end

  // Pipeline stage 1: |1 - 2x| scaled by the rate.
  logic [31:0] m1;
  always_comb begin
    m1 = x0_q[31] ? {x0_q[30:0], 1'b0} : (~{x0_q[30:0], 1'b0}) + 32'd1;
  end

  // Pipeline stage 2: find the top nonzero byte and keep a window around it.
  logic [63:0] dfl;
  logic [2:0]  j_c;
  logic [11:0] w_c;
  always_comb begin
    dfl = (d1_q < DERIV_MIN) ? DERIV_MIN : d1_q;
    j_c = 3'd1;
    w_c = {dfl[15:8], dfl[7:4]};
    for (int jj = 1; jj < 8; jj++) begin
      if (dfl[8*jj +: 8] != 8'd0) begin
        j_c = 3'(jj);
        w_c = {dfl[8*jj +: 8], dfl[8*jj-4 +: 4]};
      end
    end
  end

  // Pipeline stage 3: leading one within the byte, then exponent and table term.
  logic [2:0]  p_c;
  logic [3:0]  k_c;
  logic signed [6:0]  em;
  logic signed [24:0] lnp;
  logic signed [TERM_W-1:0] term_c;
  always_comb begin
    p_c = 3'd0;
    k_c = w2_q[3:0];
    for (int pp = 0; pp < 8; pp++) begin
      if (w2_q[pp + 4]) begin
        p_c = 3'(pp);
        k_c = w2_q[pp +: 4];
      end
    end
    em     = $signed({1'b0, j2_q, p_c}) - 7'sd61;
    lnp    = em * $signed({1'b0, LN2_Q16});
    term_c = TERM_W'(lnp) + $signed(TERM_W'({1'b0, ln_frac(k_c)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v0_q    <= push;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    meas_q <= meas_d;
    esc_q  <= esc_d;
    if (state_q == ST_IDLE && start_i) begin
      ra_q  <= ra_i;
      rb_q  <= rb_i;
      pat_q <= pattern_i;
      len_q <= len_i;
      sum_q <= '0;
    end else if (v3_q) begin
      sum_q <= sum_q + SUM_W'(term3_q);
    end
    if (state_q == ST_MULP) begin
      p_q <= p_d;
      r_q <= r_d;
    end
    x0_q    <= prod_r[60:29];
    r0_q    <= r_q;
    d1_q    <= r0_q * m1;
    j2_q    <= j_c;
    w2_q    <= w_c;
    term3_q <= term_c;
    if (state_q == ST_TIER) begin
      level_q <= level_d;
    end
  end

  assign res_o.done    = (state_q == ST_DONE);
  assign res_o.escaped = esc_q;
  assign res_o.level   = level_q;

  `ASSERT_STD(a_tier_after_drain, (state_q == ST_TIER) |-> !(v0_q || v1_q || v2_q || v3_q))
  `ASSERT_STD(a_x_in_range, (state_q == ST_MULP) |-> (x_q != 32'd0))
  `ASSERT_STD(a_pos_in_len, (state_q == ST_MULR) |-> (LEN_W'(pos_q) < len_q))

endmodule
`default_nettype wire
